@@ rtl/sks_pkg.sv @@
// sks_pkg: shared types and constants for the sorted key set.
// No dependencies; imported by sorted_key_set.
`default_nettype none

package sks_pkg;

    // Default sizes of the store
    localparam int SKS_DEPTH_DEF     = 32;
    localparam int SKS_KEY_WIDTH_DEF = 32;

    // Request and result field layout
    localparam int OP_WIDTH        = 2;
    localparam int KEY_IN_WIDTH    = 32;
    localparam int KEY_LSB         = OP_WIDTH;
    localparam int S_TDATA_WIDTH   = 40;
    localparam int COUNT_OUT_WIDTH = 6;
    localparam int M_TDATA_WIDTH   = 8;

    // Request operations
    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } sks_op_t;

endpackage

`default_nettype wire

@@ rtl/sks_ram.sv @@
// sks_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module sks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sorted_key_set.sv @@
// sorted_key_set: set of distinct keys kept in ascending order in a RAM.
// Depends on sks_pkg and sks_ram.
//
//   channel  dir  handshake              payload
//   s_       in   s_tvalid / s_tready    s_tdata: operation, key
//   m_       out  m_tvalid / m_tready    m_tdata: success, full_res, count
//   cfg_     in   cfg_valid / cfg_ready  cfg_data: signed_order
//
// One request at a time; s_tready is high only in idle. After acceptance the
// binary search runs probes, each a RAM read (SEARCH) then a compare (CMP), at
// most ceil(log2(count+1)) probes, and closes in SEARCH. Add then moves each
// entry above the slot up one slot (SHUP, which also ends the move) and then
// inserts the key (INS); remove moves each entry above the hit down (SHDN).
// FIN loads the result register, then idle takes the next request.
// Reset clears the state, the count, the pending write, the result valid and
// the order register; the RAM needs no clearing pass. A stalled result holds
// in the output register; the next request is taken meanwhile and its result
// waits until the register frees.
`default_nettype none

module sorted_key_set
    import sks_pkg::*;
#(
    parameter int DEPTH     = SKS_DEPTH_DEF,
    parameter int KEY_WIDTH = SKS_KEY_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // request stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,   // [1:0] operation, [33:2] key
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [M_TDATA_WIDTH-1:0] m_tdata,   // [0] success, [1] full_res, [7:2] count
    // configuration
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_data   // signed_order
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int KIW = (KEY_WIDTH < KEY_IN_WIDTH) ? KEY_WIDTH : KEY_IN_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_SHUP,
        ST_INS,
        ST_SHDN,
        ST_FIN
    } state_t;

    state_t                state_reg, state_next;
    sks_op_t               op_reg, op_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]         rp_reg, rp_next;
    logic                  found_reg, found_next;
    logic                  ok_reg, ok_next;
    logic                  full_reg, full_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic                  signed_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_success_reg, m_success_next;
    logic                  m_full_reg, m_full_next;
    logic [COUNT_OUT_WIDTH-1:0] m_count_reg, m_count_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [KEY_WIDTH-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [KEY_WIDTH-1:0]  ram_rdata;

    logic [CW-1:0]         mid;
    logic [KEY_WIDTH-1:0]  sign_flip;
    logic [KEY_WIDTH-1:0]  ord_entry;
    logic [KEY_WIDTH-1:0]  ord_key;

    sks_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_count_reg, m_full_reg, m_success_reg};

    // Order mapping: flipping the sign bit makes signed order unsigned
    assign sign_flip = signed_reg ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
    assign ord_entry = ram_rdata ^ sign_flip;
    assign ord_key   = key_reg ^ sign_flip;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        rp_next        = rp_reg;
        found_next     = found_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_success_next = m_success_reg;
        m_full_next    = m_full_reg;
        m_count_next   = m_count_reg;

        // pending shift write lands the entry read last cycle
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = mid[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = sks_op_t'(s_tdata[OP_WIDTH-1:0]);
                    key_next   = KEY_WIDTH'(s_tdata[KEY_LSB +: KIW]);
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    full_next  = 1'b0;
                    if (sks_op_t'(s_tdata[OP_WIDTH-1:0]) == OP_CLEAR) begin
                        cnt_next   = '0;
                        ok_next    = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid[AW-1:0];
                    mid_next   = mid;
                    state_next = ST_CMP;
                end else begin
                    case (op_reg)
                        OP_ADD: begin
                            if (found_reg) begin
                                state_next = ST_FIN;
                            end else if (cnt_reg == FULL_COUNT) begin
                                full_next  = 1'b1;
                                state_next = ST_FIN;
                            end else begin
                                rp_next    = cnt_reg;
                                state_next = ST_SHUP;
                            end
                        end
                        OP_REMOVE: begin
                            if (found_reg) begin
                                rp_next    = lo_reg;
                                state_next = ST_SHDN;
                            end else begin
                                state_next = ST_FIN;
                            end
                        end
                        OP_CONTAINS: begin
                            ok_next    = found_reg;
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // Probe result: narrow the range; an equal entry is the lower bound
            ST_CMP: begin
                if (ord_entry < ord_key) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                if (ord_entry == ord_key) begin
                    found_next = 1'b1;
                end
                state_next = ST_SEARCH;
            end

            // Move entries up one slot, from the top down to the insert point
            ST_SHUP: begin
                if (rp_reg > lo_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(rp_reg - 1'b1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = rp_reg[AW-1:0];
                    rp_next      = rp_reg - 1'b1;
                end else begin
                    state_next = ST_INS;
                end
            end

            ST_INS: begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg[AW-1:0];
                ram_wdata  = key_reg;
                cnt_next   = cnt_reg + 1'b1;
                ok_next    = 1'b1;
                state_next = ST_FIN;
            end

            // Move entries down one slot, from the hit up to the top
            ST_SHDN: begin
                if ((rp_reg + 1'b1) < cnt_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(rp_reg + 1'b1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = rp_reg[AW-1:0];
                    rp_next      = rp_reg + 1'b1;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_FIN;
                end
            end

            // Hand the result to the output register once it is free
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_success_next = ok_reg;
                    m_full_next    = full_reg;
                    m_count_next   = COUNT_OUT_WIDTH'(cnt_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            signed_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                signed_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        rp_reg        <= rp_next;
        found_reg     <= found_next;
        ok_reg        <= ok_next;
        full_reg      <= full_next;
        wr_addr_reg   <= wr_addr_next;
        m_success_reg <= m_success_next;
        m_full_reg    <= m_full_next;
        m_count_reg   <= m_count_next;
    end

endmodule

`default_nettype wire

@@ verif/sorted_key_set_tb.sv @@
// sorted_key_set_tb: self-checking bench for the sorted key set.
// Drives add/remove/contains/clear requests, predicts each reply from a shadow
// copy of the set and compares it; depends on sks_pkg and sorted_key_set.
`timescale 1ns / 100ps

module sorted_key_set_tb;
    import sks_pkg::*;

    localparam int SET_DEPTH   = SKS_DEPTH_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 64;

    // One request as it enters the block
    typedef struct packed {
        logic [KEY_IN_WIDTH-1:0] key;
        sks_op_t                 op;
    } request_t;

    // One reply, laid out as m_tdata (success in bit 0)
    typedef struct packed {
        logic [COUNT_OUT_WIDTH-1:0] count;
        logic                       full_res;
        logic                       success;
    } reply_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_data  = 1'b0;

    // Shadow of the set contents and the order register
    logic [KEY_IN_WIDTH-1:0] shadow_keys [SET_DEPTH];
    int                      shadow_count = 0;
    bit                      shadow_signed = 1'b0;

    request_t request_backlog [$];
    reply_t   reply_queue [$];
    request_t in_flight;
    bit       request_live = 1'b0;
    bit       steady_flow  = 1'b0;
    int       send_gap     = 0;
    int       stall_left   = 0;
    int       mismatches   = 0;
    int       dead_cycles  = 0;
    reply_t   got_reply;
    reply_t   want_reply;
    logic [S_TDATA_WIDTH-1:0] s_word;

    sorted_key_set dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Key rank: flipping the sign bit turns signed order into unsigned order
    function automatic logic [KEY_IN_WIDTH-1:0] rank_of(input logic [KEY_IN_WIDTH-1:0] k);
        return shadow_signed ? (k ^ 32'h8000_0000) : k;
    endfunction

    // First slot whose key is not below k
    function automatic int lower_slot(input logic [KEY_IN_WIDTH-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (rank_of(shadow_keys[mid]) < rank_of(k)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // Apply one request to the shadow set and return the reply it owes
    function automatic reply_t set_apply(input request_t req);
        reply_t r;
        int     slot;
        bit     hit;
        int     i;
        r = '0;
        if (req.op == OP_CLEAR) begin
            shadow_count = 0;
            r.success = 1'b1;
        end else begin
            slot = lower_slot(req.key);
            hit = (slot < shadow_count) && (shadow_keys[slot] == req.key);
            case (req.op)
                OP_ADD: begin
                    // duplicate check comes before the full check
                    if (!hit) begin
                        if (shadow_count >= SET_DEPTH) begin
                            r.full_res = 1'b1;
                        end else begin
                            for (i = shadow_count; i > slot; i--)
                                shadow_keys[i] = shadow_keys[i-1];
                            shadow_keys[slot] = req.key;
                            shadow_count++;
                            r.success = 1'b1;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        for (i = slot; i + 1 < shadow_count; i++)
                            shadow_keys[i] = shadow_keys[i+1];
                        shadow_count--;
                        r.success = 1'b1;
                    end
                end
                default: begin
                    r.success = hit;
                end
            endcase
        end
        r.count = shadow_count[COUNT_OUT_WIDTH-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected 'h%0h, got 'h%0h", $time, what, want_v, got_v);
    endtask

    // Request driver: holds tvalid until accepted, inserts random gaps between requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            request_live = 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_queue.push_back(set_apply(in_flight));
                request_live = 1'b0;
            end
            if (!request_live) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_backlog.size() != 0 && !steady_flow &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    in_flight = request_backlog.pop_front();
                    request_live = 1'b1;
                    s_word = '0;
                    s_word[OP_WIDTH-1:0] = in_flight.op;
                    s_word[KEY_LSB +: KEY_IN_WIDTH] = in_flight.key;
                    s_tvalid <= 1'b1;
                    s_tdata <= s_word;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor and result-side backpressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_reply = m_tdata;
            if (reply_queue.size() == 0) begin
                flag_mismatch("reply with no request outstanding", 8'h00, m_tdata);
            end else begin
                want_reply = reply_queue.pop_front();
                if (got_reply.success !== want_reply.success)
                    flag_mismatch("success", 8'(want_reply.success),
                                  8'(got_reply.success));
                if (got_reply.full_res !== want_reply.full_res)
                    flag_mismatch("full_res", 8'(want_reply.full_res),
                                  8'(got_reply.full_res));
                if (got_reply.count !== want_reply.count)
                    flag_mismatch("count", 8'(want_reply.count), 8'(got_reply.count));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            dead_cycles = 0;
        end else begin
            dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_request(input sks_op_t op, input logic [KEY_IN_WIDTH-1:0] key);
        request_t req;
        req.op  = op;
        req.key = key;
        request_backlog.push_back(req);
    endtask

    // Block until every request has gone in and every reply has come back
    task automatic wait_drained;
        do @(posedge aclk);
        while (request_backlog.size() != 0 || request_live || reply_queue.size() != 0);
    endtask

    task automatic write_signed_order(input bit value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        shadow_signed = value;
        cfg_valid <= 1'b0;
    endtask

    // Key pool: extremes, keys around the sign and zero boundaries, random keys
    function automatic logic [KEY_IN_WIDTH-1:0] pool_key();
        logic [KEY_IN_WIDTH-1:0] off;
        off = $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            1: return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'h7FFF_FFFD + off;
            3: return 32'hFFFF_FFFD + off;
            default: return $urandom;
        endcase
    endfunction

    // One random phase: set the order, empty the set, then weighted requests
    task automatic run_phase(input bit order, input int n_items, input int add_pct,
                             input int remove_pct, input int contains_pct,
                             input int pool_size);
        logic [KEY_IN_WIDTH-1:0] pool [$];
        logic [KEY_IN_WIDTH-1:0] key;
        int pick;
        int i;
        write_signed_order(order);
        for (i = 0; i < pool_size; i++)
            pool.push_back(pool_key());
        queue_request(OP_CLEAR, $urandom);
        for (i = 1; i < n_items; i++) begin
            key = ($urandom_range(0, 19) == 0) ? $urandom
                                                : pool[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                queue_request(OP_ADD, key);
            else if (pick < add_pct + remove_pct)
                queue_request(OP_REMOVE, key);
            else if (pick < add_pct + remove_pct + contains_pct)
                queue_request(OP_CONTAINS, key);
            else
                queue_request(OP_CLEAR, key);
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, unsigned order: empty set, extremes, duplicate, absent keys, clear
        write_signed_order(1'b0);
        queue_request(OP_CONTAINS, 32'h0000_0005);
        queue_request(OP_REMOVE,   32'h0000_0005);
        queue_request(OP_ADD,      32'h0000_0000);
        queue_request(OP_ADD,      32'hFFFF_FFFF);
        queue_request(OP_ADD,      32'h8000_0000);
        queue_request(OP_ADD,      32'h7FFF_FFFF);
        queue_request(OP_ADD,      32'h0000_0001);
        queue_request(OP_ADD,      32'h0000_0000);
        queue_request(OP_CONTAINS, 32'h7FFF_FFFF);
        queue_request(OP_CONTAINS, 32'h0000_0002);
        queue_request(OP_REMOVE,   32'h0000_0002);
        queue_request(OP_REMOVE,   32'h8000_0000);
        queue_request(OP_CONTAINS, 32'h8000_0000);
        queue_request(OP_REMOVE,   32'hFFFF_FFFF);
        queue_request(OP_REMOVE,   32'h0000_0000);
        queue_request(OP_CLEAR,    32'hFFFF_FFFF);
        queue_request(OP_CONTAINS, 32'h0000_0001);
        queue_request(OP_ADD,      32'h1234_5678);
        wait_drained();

        // Directed, signed order: negative keys must sort below positive ones
        write_signed_order(1'b1);
        queue_request(OP_CLEAR,    32'h0000_0000);
        queue_request(OP_ADD,      32'h8000_0000);
        queue_request(OP_ADD,      32'h7FFF_FFFF);
        queue_request(OP_ADD,      32'hFFFF_FFFF);
        queue_request(OP_ADD,      32'h0000_0000);
        queue_request(OP_CONTAINS, 32'hFFFF_FFFF);
        queue_request(OP_REMOVE,   32'h8000_0000);
        queue_request(OP_CONTAINS, 32'h0000_0000);
        wait_drained();

        // Random phases; add-heavy ones keep the store near full
        run_phase(1'b1, 300, 60, 12, 26, 40);
        run_phase(1'b0, 300, 40, 30, 28, 24);
        run_phase(1'b1, 300, 45, 25, 28, 36);
        run_phase(1'b0, 250, 62, 10, 26, 48);
        steady_flow = 1'b1;
        run_phase(1'b1, 250, 50, 22, 26, 40);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && reply_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
